@@ rtl/och_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package och_pkg;

    localparam int SYMBOLS_PER_WORD = 4;
    localparam int BITS_PER_SYMBOL  = 2;
    localparam int COUNT_WIDTH      = 32;

    localparam int WORD_BITS  = SYMBOLS_PER_WORD * BITS_PER_SYMBOL;
    localparam int CORR_BITS  = SYMBOLS_PER_WORD - 1;
    localparam int BIN_AW     = 2 * CORR_BITS;
    localparam int BIN_TOTAL  = 1 << BIN_AW;

    // stream widths rounded up to whole bytes
    localparam int S_TDATA_W  = ((2 * WORD_BITS + 2 * CORR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * CORR_BITS + COUNT_WIDTH + 1 + 7) / 8) * 8;

    // item kind carried in tuser
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic                 is_read;
        logic [CORR_BITS-1:0] row;
        logic [CORR_BITS-1:0] col;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_LOOKUP
    } back_state_t;

    // one bit per shift, shift one lands in the msb
    function automatic logic [CORR_BITS-1:0] correlate(
        input logic [WORD_BITS-1:0] x,
        input logic [WORD_BITS-1:0] y
    );
        logic [CORR_BITS-1:0] c;
        logic [WORD_BITS-1:0] ys;
        logic [WORD_BITS-1:0] keep;
        c = '0;
        for (int s = 1; s < SYMBOLS_PER_WORD; s++)
        begin
            ys   = y >> (s * BITS_PER_SYMBOL);
            keep = {WORD_BITS{1'b1}} >> (s * BITS_PER_SYMBOL);
            c[CORR_BITS-s] = (((x ^ ys) & keep) == '0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/overlap_correlation_histogram.sv @@
// Overlap correlation histogram.
// Input stream (s_axis): tuser = op (0 accumulate word pair, 1 read bin);
// tdata carries word_a, word_b, bin_row, bin_col. An accumulate transfer
// computes corr_ab and corr_ba of the two words and bumps the bin
// [corr_ab][corr_ba], saturating at its maximum; a read transfer returns
// the count of bin [bin_row][bin_col] and leaves the histogram alone.
// Output stream (m_axis): exactly one transfer per input transfer, in order,
// carrying corr_ab and corr_ba (bin_row and bin_col for a read), bin_count
// and saturated. An input transfer goes through the front register, the
// queue write, the memory fetch, then the update into the result register.
// The back end takes a new item only once the read-modify-write of the
// single-port histogram memory (fetch, then update) for the last one is done.
// Reset clears all 64 bins at once through per-bin written flags; items are
// taken from the first cycle after reset.
// When the receiver stalls, the result register holds its transfer, the
// back end stops, the two-entry queue and front register fill, and then
// s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module overlap_correlation_histogram (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // word_a[7:0], word_b[15:8], bin_row[18:16], bin_col[21:19], zero pad
    input  wire logic [och_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op[0]
    input  wire logic                       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // corr_ab[2:0], corr_ba[5:3], bin_count[37:6], saturated[38], zero pad
    output logic [och_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import och_pkg::*;

    localparam int WB_LO  = WORD_BITS;
    localparam int ROW_LO = 2 * WORD_BITS;
    localparam int COL_LO = ROW_LO + CORR_BITS;
    localparam int OUT_W  = 2 * CORR_BITS + COUNT_WIDTH + 1;

    logic                   push;
    cmd_t                   push_cmd;
    logic                   q_full;
    logic                   q_pop;
    cmd_t                   q_cmd;
    logic                   q_not_empty;
    logic [CORR_BITS-1:0]   out_row;
    logic [CORR_BITS-1:0]   out_col;
    logic [COUNT_WIDTH-1:0] out_count;
    logic                   out_sat;

    // accept and classify
    och_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_word_a (s_axis_tdata[WORD_BITS-1:0]),
        .in_word_b (s_axis_tdata[WB_LO +: WORD_BITS]),
        .in_row    (s_axis_tdata[ROW_LO +: CORR_BITS]),
        .in_col    (s_axis_tdata[COL_LO +: CORR_BITS]),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_full    (q_full)
    );

    // command queue between front and back
    och_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (q_cmd),
        .not_empty (q_not_empty)
    );

    // histogram update and result
    och_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_count   (out_count),
        .out_sat     (out_sat)
    );

    assign m_axis_tdata = {{(M_TDATA_W-OUT_W){1'b0}}, out_sat, out_count, out_col, out_row};

endmodule

`default_nettype wire

@@ rtl/och_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module och_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         in_op,
    input  wire logic [och_pkg::WORD_BITS-1:0] in_word_a,
    input  wire logic [och_pkg::WORD_BITS-1:0] in_word_b,
    input  wire logic [och_pkg::CORR_BITS-1:0] in_row,
    input  wire logic [och_pkg::CORR_BITS-1:0] in_col,
    output logic                              push,
    output och_pkg::cmd_t                     push_cmd,
    input  wire logic                         q_full
);
    import och_pkg::*;

    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    // classify: reads keep their address, accumulates get their bin
    always_comb
    begin
        cmd_next.is_read = (in_op == OP_READ);
        if (in_op == OP_READ)
        begin
            cmd_next.row = in_row;
            cmd_next.col = in_col;
        end
        else
        begin
            cmd_next.row = correlate(in_word_a, in_word_b);
            cmd_next.col = correlate(in_word_b, in_word_a);
        end
    end

    assign push     = valid_reg && !q_full;
    assign push_cmd = cmd_reg;
    assign in_ready = !valid_reg || !q_full;
    assign take     = in_valid && in_ready;

    // front holding stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/och_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module och_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  och_pkg::cmd_t      push_cmd,
    output logic               full,
    input  wire logic          pop,
    output och_pkg::cmd_t      pop_cmd,
    output logic               not_empty
);
    import och_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/och_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module och_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_not_empty,
    input  och_pkg::cmd_t                        q_cmd,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [och_pkg::CORR_BITS-1:0]        out_row,
    output logic [och_pkg::CORR_BITS-1:0]        out_col,
    output logic [och_pkg::COUNT_WIDTH-1:0]      out_count,
    output logic                                 out_sat
);
    import och_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    back_state_t state_reg;
    back_state_t state_next;

    logic [COUNT_WIDTH-1:0] mem [BIN_TOTAL];
    logic [BIN_TOTAL-1:0]   written_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   hit_reg;
    cmd_t                   cmd_reg;

    logic                   out_valid_reg;
    logic [CORR_BITS-1:0]   row_reg;
    logic [CORR_BITS-1:0]   col_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   sat_reg;

    logic [BIN_AW-1:0]      rd_addr;
    logic [BIN_AW-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic                   load_out;
    logic                   wr_en;
    logic                   out_take;

    assign rd_addr  = {q_cmd.row, q_cmd.col};
    assign wr_addr  = {cmd_reg.row, cmd_reg.col};
    assign out_take = out_valid_reg && out_ready;

    // saturating increment of the fetched bin; a read keeps the count as fetched
    always_comb
    begin
        cur_count = hit_reg ? rd_data_reg : '0;
        if (cmd_reg.is_read || cur_count == COUNT_MAX)
        begin
            new_count = cur_count;
        end
        else
        begin
            new_count = cur_count + COUNT_WIDTH'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty && (!out_valid_reg || out_ready))
                begin
                    state_next = BK_LOOKUP;
                end
            end
            BK_LOOKUP:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        wr_en    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_not_empty && (!out_valid_reg || out_ready);
            end
            BK_LOOKUP:
            begin
                load_out = 1'b1;
                wr_en    = !cmd_reg.is_read;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // histogram memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= new_count;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[rd_addr];
            hit_reg     <= written_reg[rd_addr];
            cmd_reg     <= q_cmd;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            row_reg   <= cmd_reg.row;
            col_reg   <= cmd_reg.col;
            count_reg <= new_count;
            sat_reg   <= (new_count == COUNT_MAX);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_count = count_reg;
    assign out_sat   = sat_reg;

endmodule

`default_nettype wire
